### rtl/yrgb_pkg.sv
`timescale 1ns / 1ps
// Shared constants, register codes and the color clamp function for the
// YUYV to mirrored RGB converter. No dependencies.
package yrgb_pkg;

  localparam int CFG_W      = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int DIM_W      = CFG_W + 1;
  localparam int INDEX_W    = 24;
  localparam int PIX_W      = 8;
  localparam int SUM_W      = 19;

  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_HEIGHT_DEF = 4096;

  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  localparam logic [CFG_W-1:0] LINE_WIDTH_RST   = 13'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd480;

  // Full-range BT.601 coefficients in Q8.
  localparam logic signed [SUM_W-1:0] Q_RED_V   = 19'sd359;
  localparam logic signed [SUM_W-1:0] Q_GREEN_U = 19'sd88;
  localparam logic signed [SUM_W-1:0] Q_GREEN_V = 19'sd183;
  localparam logic signed [SUM_W-1:0] Q_BLUE_U  = 19'sd454;
  localparam logic signed [SUM_W-1:0] CHROMA_OFS = 19'sd128;

  // Drops the Q8 fraction of a sum and clamps it to a byte.
  function automatic logic [PIX_W-1:0] to_byte(input logic signed [SUM_W-1:0] s);
    logic [PIX_W-1:0] res;
    if (s[SUM_W-1]) begin
      res = '0;
    end else if (|s[SUM_W-2:16]) begin
      res = '1;
    end else begin
      res = s[15:8];
    end
    return res;
  endfunction

endpackage

### rtl/yrgb_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for macropixels in and RGB pairs out.
// Depends on yrgb_pkg for the field widths.
interface yrgb_in_if;
  logic                          valid;
  logic                          ready;
  logic [yrgb_pkg::PIX_W-1:0]    luma_first;
  logic [yrgb_pkg::PIX_W-1:0]    chroma_blue;
  logic [yrgb_pkg::PIX_W-1:0]    luma_second;
  logic [yrgb_pkg::PIX_W-1:0]    chroma_red;

  modport source (output valid, luma_first, chroma_blue, luma_second, chroma_red,
                  input ready);
  modport sink (input valid, luma_first, chroma_blue, luma_second, chroma_red,
                output ready);
endinterface

interface yrgb_out_if;
  logic                          valid;
  logic                          ready;
  logic [yrgb_pkg::PIX_W-1:0]    red_first;
  logic [yrgb_pkg::PIX_W-1:0]    green_first;
  logic [yrgb_pkg::PIX_W-1:0]    blue_first;
  logic [yrgb_pkg::PIX_W-1:0]    red_second;
  logic [yrgb_pkg::PIX_W-1:0]    green_second;
  logic [yrgb_pkg::PIX_W-1:0]    blue_second;
  logic [yrgb_pkg::INDEX_W-1:0]  pixel_index;
  logic                          line_end;
  logic                          frame_end;

  modport source (output valid, red_first, green_first, blue_first, red_second,
                  green_second, blue_second, pixel_index, line_end, frame_end,
                  input ready);
  modport sink (input valid, red_first, green_first, blue_first, red_second,
                green_second, blue_second, pixel_index, line_end, frame_end,
                output ready);
endinterface

### rtl/yuyv_to_rgb_mirrored_top.sv
`timescale 1ns / 1ps
// YUYV 4:2:2 to RGB888 converter with horizontal line mirroring.
// Depends on yrgb_pkg and the channel interfaces in yrgb_if.sv.
//
// Usage: each transfer on in_ch carries one macropixel (Y0, U, Y1, V). Each
// transfer on out_ch carries both converted pixels, the mirrored frame-memory
// index of the first pixel (the second pixel sits one below it), and flags for
// the last pair of a line and of a frame.
// Configuration: cfg_we writes cfg_wdata into the register selected by
// cfg_index (line width, frame height). Write only while the block is idle.
// Input passes the input register, then the result register. The block takes
// one macropixel per cycle; throughput is bounded only by the output side.
// Position counters advance at the input register stage, the color math sits
// between the input register and the result register.
// Reset clears both pipeline stages and the position counters and loads the
// default geometry of 640 by 480. When out_ch.ready is low while a result is
// valid, the result register holds, the input register fills, and in_ch.ready
// then drops until the result is taken.
module yuyv_to_rgb_mirrored_top #(
  parameter int MAX_WIDTH  = yrgb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = yrgb_pkg::MAX_HEIGHT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  yrgb_in_if.sink                          in_ch,
  yrgb_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [yrgb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [yrgb_pkg::CFG_W-1:0]       cfg_wdata
);

  localparam int PAIRS_MAX = MAX_WIDTH / 2;
  localparam int CW = (PAIRS_MAX > 1) ? $clog2(PAIRS_MAX) : 1;
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int DW = yrgb_pkg::DIM_W;
  localparam int IW = yrgb_pkg::INDEX_W;
  localparam int PW = yrgb_pkg::PIX_W;
  localparam int SW = yrgb_pkg::SUM_W;

  // Configuration registers.
  logic [yrgb_pkg::CFG_W-1:0] line_width_r;
  logic [yrgb_pkg::CFG_W-1:0] frame_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r   <= yrgb_pkg::LINE_WIDTH_RST;
      frame_height_r <= yrgb_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        yrgb_pkg::REG_LINE_WIDTH:   line_width_r   <= cfg_wdata;
        yrgb_pkg::REG_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Handshake for the two stages.
  logic s1_v_r, s2_v_r;
  logic adv2, in_acc;

  assign adv2        = !s2_v_r || out_ch.ready;
  assign in_ch.ready = !s1_v_r || adv2;
  assign in_acc      = in_ch.valid && in_ch.ready;

  // Position counters.
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [IW-1:0] base_r, base_nxt;

  logic [DW-1:0] pairs_raw, pairs, hgt_raw, hgt;
  logic [DW-1:0] col_ext, col_eff, row_ext, row_eff, width, offset;
  logic          lend, fend;
  logic [IW-1:0] index;

  always_comb begin
    pairs_raw = {2'b00, line_width_r[yrgb_pkg::CFG_W-1:1]};
    if (pairs_raw == '0) begin
      pairs = DW'(1);
    end else if (pairs_raw > DW'(PAIRS_MAX)) begin
      pairs = DW'(PAIRS_MAX);
    end else begin
      pairs = pairs_raw;
    end

    hgt_raw = {1'b0, frame_height_r};
    if (hgt_raw == '0) begin
      hgt = DW'(1);
    end else if (hgt_raw > DW'(MAX_HEIGHT)) begin
      hgt = DW'(MAX_HEIGHT);
    end else begin
      hgt = hgt_raw;
    end

    // A counter left out of range by a register write ends its line or frame.
    col_ext = DW'(col_r);
    col_eff = (col_ext >= pairs) ? pairs - DW'(1) : col_ext;
    row_ext = DW'(row_r);
    row_eff = (row_ext >= hgt) ? hgt - DW'(1) : row_ext;

    lend   = (col_eff == pairs - DW'(1));
    fend   = lend && (row_eff == hgt - DW'(1));
    width  = pairs << 1;
    offset = width - DW'(1) - (col_eff << 1);
    index  = base_r + IW'(offset);

    if (lend) begin
      col_nxt = '0;
      if (fend) begin
        row_nxt  = '0;
        base_nxt = '0;
      end else begin
        row_nxt  = RW'(row_eff + DW'(1));
        base_nxt = base_r + IW'(width);
      end
    end else begin
      col_nxt  = CW'(col_eff + DW'(1));
      row_nxt  = RW'(row_eff);
      base_nxt = base_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      base_r <= '0;
    end else if (in_acc) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      base_r <= base_nxt;
    end
  end

  // Input register stage.
  logic [PW-1:0] y0_r, u_r, y1_r, v_r;
  logic [IW-1:0] s1_index_r;
  logic          s1_lend_r, s1_fend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      y0_r       <= in_ch.luma_first;
      u_r        <= in_ch.chroma_blue;
      y1_r       <= in_ch.luma_second;
      v_r        <= in_ch.chroma_red;
      s1_index_r <= index;
      s1_lend_r  <= lend;
      s1_fend_r  <= fend;
    end
  end

  // Color conversion; the chroma products are shared by both pixels.
  logic signed [SW-1:0] du, dv, p_rv, p_gu, p_gv, p_bu, ys0, ys1;

  always_comb begin
    du   = SW'($signed({1'b0, u_r})) - yrgb_pkg::CHROMA_OFS;
    dv   = SW'($signed({1'b0, v_r})) - yrgb_pkg::CHROMA_OFS;
    p_rv = yrgb_pkg::Q_RED_V * dv;
    p_gu = yrgb_pkg::Q_GREEN_U * du;
    p_gv = yrgb_pkg::Q_GREEN_V * dv;
    p_bu = yrgb_pkg::Q_BLUE_U * du;
    ys0  = $signed({3'b000, y0_r, 8'h00});
    ys1  = $signed({3'b000, y1_r, 8'h00});
  end

  // Result register stage.
  logic [PW-1:0] r0_r, g0_r, b0_r, r1_r, g1_r, b1_r;
  logic [IW-1:0] s2_index_r;
  logic          s2_lend_r, s2_fend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv2) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && s1_v_r) begin
      r0_r       <= yrgb_pkg::to_byte(ys0 + p_rv);
      g0_r       <= yrgb_pkg::to_byte(ys0 - p_gu - p_gv);
      b0_r       <= yrgb_pkg::to_byte(ys0 + p_bu);
      r1_r       <= yrgb_pkg::to_byte(ys1 + p_rv);
      g1_r       <= yrgb_pkg::to_byte(ys1 - p_gu - p_gv);
      b1_r       <= yrgb_pkg::to_byte(ys1 + p_bu);
      s2_index_r <= s1_index_r;
      s2_lend_r  <= s1_lend_r;
      s2_fend_r  <= s1_fend_r;
    end
  end

  assign out_ch.valid        = s2_v_r;
  assign out_ch.red_first    = r0_r;
  assign out_ch.green_first  = g0_r;
  assign out_ch.blue_first   = b0_r;
  assign out_ch.red_second   = r1_r;
  assign out_ch.green_second = g1_r;
  assign out_ch.blue_second  = b1_r;
  assign out_ch.pixel_index  = s2_index_r;
  assign out_ch.line_end     = s2_lend_r;
  assign out_ch.frame_end    = s2_fend_r;

  // The end of a frame is always also the end of a line.
  a_fend_lend : assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (!out_ch.frame_end || out_ch.line_end))
    else $error("frame end without line end");

  // The last pair of a line returns the column counter to zero.
  a_col_wrap : assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && lend) |=> (col_r == '0))
    else $error("column did not wrap at line end");

  // The last pair of a frame clears the row counter and the line base.
  a_frame_wrap : assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && fend) |=> (row_r == '0 && base_r == '0))
    else $error("row or base did not clear at frame end");

  // Inside a line the row and base stay put.
  a_line_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !lend) |=> ($stable(base_r) && DW'(row_r) == $past(row_eff)))
    else $error("row or base moved inside a line");

  // A full input stage with a stalled output keeps the input side closed.
  a_stall : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s2_v_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("input taken while both stages are full");

endmodule
